@@ design/datarate_mantissa_exponent_codec_top_defines.svh @@
// assertion macros for the data rate mantissa/exponent codec
// included by the rtl files that carry concurrent assertions
`ifndef DATARATE_MANTISSA_EXPONENT_CODEC_TOP_DEFINES_SVH
`define DATARATE_MANTISSA_EXPONENT_CODEC_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define DMEC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define DMEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/dmec_pkg.sv @@
// shared widths, constants and controller/datapath structs of the rate codec
// no dependencies
`default_nettype none

package dmec_pkg;

    localparam int CRYSTAL_W = 26;
    localparam int TARGET_W  = 20;
    localparam int MANT_W    = 16;
    localparam int EXP_W     = 4;
    localparam int RATE_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int MULB_W    = MANT_W + 1;
    localparam int PROD_W    = CRYSTAL_W + MULB_W;
    localparam int DVD_W     = TARGET_W + 32;
    localparam int DIFF_W    = 64;
    localparam int SH_W      = 6;
    localparam int DIV_STEPS = DVD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [EXP_W-1:0]     EXPONENT_LIMIT = 4'd12;
    localparam logic [SH_W-1:0]      SHIFT_BASE     = 6'd33;
    localparam logic [SH_W-1:0]      SHIFT_ZERO     = 6'd32;
    localparam logic [CRYSTAL_W-1:0] CRYSTAL_RESET  = 26'd50000000;
    localparam logic [CRYSTAL_W-1:0] THRESH_RESET   = 26'd30000000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CRYSTAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 1'b1;

    // input command codes
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    typedef struct packed {
        logic load;
        logic prep;
        logic search_step;
        logic div_init;
        logic div_step;
        logic mul_round;
        logic diff;
        logic out_enc;
        logic mul_dec;
        logic out_dec;
    } t_dmec_cmd;

    typedef struct packed {
        logic is_dec;
        logic search_done;
        logic fd_zero;
        logic div_last;
        logic out_free;
    } t_dmec_stat;

endpackage

`default_nettype wire

@@ design/dmec_in_if.sv @@
// input channel of the rate codec: valid/ready plus one request
// depends on dmec_pkg
`default_nettype none

interface dmec_in_if import dmec_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                command;
    logic [TARGET_W-1:0] target_rate;
    logic [MANT_W-1:0]   code_mantissa;
    logic [EXP_W-1:0]    code_exponent;

    modport source (output valid, command, target_rate, code_mantissa, code_exponent,
                    input ready);
    modport sink (input valid, command, target_rate, code_mantissa, code_exponent,
                  output ready);
endinterface

`default_nettype wire

@@ design/dmec_out_if.sv @@
// output channel of the rate codec: valid/ready plus one result
// depends on dmec_pkg
`default_nettype none

interface dmec_out_if import dmec_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MANT_W-1:0] found_mantissa;
    logic [EXP_W-1:0]  found_exponent;
    logic [RATE_W-1:0] rate_value;

    modport source (output valid, found_mantissa, found_exponent, rate_value,
                    input ready);
    modport sink (input valid, found_mantissa, found_exponent, rate_value,
                  output ready);
endinterface

`default_nettype wire

@@ design/datarate_mantissa_exponent_codec_top.sv @@
// top level of the data rate mantissa/exponent codec
// depends on dmec_pkg, dmec_in_if, dmec_out_if, dmec_ctrl, dmec_datapath
`default_nettype none

// Converts a data rate in bit/s into the 16-bit mantissa and 4-bit exponent
// of the rate register (command 0), or a mantissa/exponent code back into a
// rate (command 1). The digital clock is the crystal register, halved when it
// is above the threshold register; both registers are written through the
// plain write port (index 0 crystal, index 1 threshold), by the user only while
// the block is idle, which the block itself does not enforce. One request is
// worked on at a time; the result sits in an output register, so the next
// request is taken while an earlier result waits. Decode does one multiply
// and one shift. Encode tries one exponent at a time in the search, then a
// 52-step restoring divider (one quotient bit a cycle) finds the mantissa,
// followed by a multiply and a distance compare for rounding. With a zero
// digital clock the divider and the rounding are skipped and the mantissa is 0.
module datarate_mantissa_exponent_codec_top import dmec_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CRYSTAL_W-1:0] i_cfg_data,
    // request and result channels
    dmec_in_if.sink                   i_in,
    dmec_out_if.source                o_out
);

    t_dmec_cmd  cmd;
    t_dmec_stat stat;

    // sequencer: accepts a request only when idle
    dmec_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // arithmetic, config registers and the result register
    dmec_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_in.command),
        .i_target_rate    (i_in.target_rate),
        .i_code_mantissa  (i_in.code_mantissa),
        .i_code_exponent  (i_in.code_exponent),
        .i_out_ready      (o_out.ready),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_out_valid      (o_out.valid),
        .o_found_mantissa (o_out.found_mantissa),
        .o_found_exponent (o_out.found_exponent),
        .o_rate_value     (o_out.rate_value)
    );

endmodule

`default_nettype wire

@@ design/dmec_ctrl.sv @@
// sequencer of the rate codec: steps the datapath through search, divide, round, or the decode multiply
// depends on dmec_pkg
`default_nettype none

module dmec_ctrl import dmec_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dmec_stat i_stat,
    output t_dmec_cmd       o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_PREP    = 4'd1;
    localparam logic [3:0] S_SEARCH  = 4'd2;
    localparam logic [3:0] S_DIVINIT = 4'd3;
    localparam logic [3:0] S_DIV     = 4'd4;
    localparam logic [3:0] S_MUL     = 4'd5;
    localparam logic [3:0] S_DIFF    = 4'd6;
    localparam logic [3:0] S_ENCOUT  = 4'd7;
    localparam logic [3:0] S_DECMUL  = 4'd8;
    localparam logic [3:0] S_DECOUT  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_stat.is_dec ? S_DECMUL : S_SEARCH;
            end
            S_SEARCH: begin
                if (i_stat.search_done) begin
                    n_state = i_stat.fd_zero ? S_ENCOUT : S_DIVINIT;
                end else begin
                    o_cmd.search_step = 1'b1;
                end
            end
            S_DIVINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_round = 1'b1;
                n_state         = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_ENCOUT;
            end
            S_ENCOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_enc = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_DECMUL: begin
                o_cmd.mul_dec = 1'b1;
                n_state       = S_DECOUT;
            end
            S_DECOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_dec = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ design/dmec_datapath.sv @@
// datapath of the rate codec: config registers, shared multiplier,
// exponent search, restoring divider, rounding and output register; depends on dmec_pkg
`default_nettype none

`include "datarate_mantissa_exponent_codec_top_defines.svh"

module dmec_datapath import dmec_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CRYSTAL_W-1:0] i_cfg_data,
    input  wire logic                 i_command,
    input  wire logic [TARGET_W-1:0]  i_target_rate,
    input  wire logic [MANT_W-1:0]    i_code_mantissa,
    input  wire logic [EXP_W-1:0]     i_code_exponent,
    input  wire logic                 i_out_ready,
    input  wire t_dmec_cmd            i_cmd,
    output t_dmec_stat                o_stat,
    output logic                      o_out_valid,
    output logic [MANT_W-1:0]         o_found_mantissa,
    output logic [EXP_W-1:0]          o_found_exponent,
    output logic [RATE_W-1:0]         o_rate_value
);

    logic [CRYSTAL_W-1:0] r_crystal;
    logic [CRYSTAL_W-1:0] r_thresh;

    logic                 r_cmd;
    logic [TARGET_W-1:0]  r_target;
    logic [MANT_W-1:0]    r_mant;
    logic [EXP_W-1:0]     r_exp;
    logic [CRYSTAL_W-1:0] r_fd;
    logic [PROD_W-1:0]    r_p0;
    logic [PROD_W-1:0]    r_p1;
    logic [EXP_W-1:0]     r_se;
    logic [DVD_W-1:0]     r_t;
    logic [DVD_W-1:0]     r_dvd;
    logic [CRYSTAL_W-1:0] r_rem;
    logic [MANT_W-1:0]    r_q;
    logic [CNT_W-1:0]     r_cnt;
    logic [PROD_W-1:0]    r_prod;
    logic [DIFF_W-1:0]    r_d1;
    logic [DIFF_W-1:0]    r_d2;
    logic                 r_out_valid;

    logic [SH_W-1:0]      search_sh;
    logic [PROD_W-1:0]    search_max;
    logic                 search_hit;
    logic [DVD_W-1:0]     t_val;
    logic [CRYSTAL_W:0]   rem_sh;
    logic                 q_bit;
    logic [MULB_W-1:0]    mul_b;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W:0]      hi_val;
    logic [SH_W-1:0]      dec_sh;
    logic                 round_up;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crystal <= CRYSTAL_RESET;
            r_thresh  <= THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CRYSTAL: r_crystal <= i_cfg_data;
                REG_THRESH:  r_thresh  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // max rate of the current exponent, mantissa all ones
    always_comb begin
        search_sh  = (r_se == '0) ? SHIFT_ZERO : SHIFT_BASE - SH_W'(r_se);
        search_max = ((r_se == '0) ? r_p0 : r_p1) >> search_sh;
        search_hit = PROD_W'(r_target) <= search_max;
    end

    // dividend for the chosen exponent
    assign t_val = DVD_W'(r_target) << search_sh;

    // one restoring division step
    always_comb begin
        rem_sh = {r_rem, r_dvd[DVD_W-1]};
        q_bit  = rem_sh >= {1'b0, r_fd};
    end

    // shared multiplier, digital clock times a 17-bit mantissa operand
    assign mul_b = i_cmd.mul_dec ? {r_exp != '0, r_mant} : {r_se != '0, r_q};
    assign prod  = PROD_W'(r_fd) * PROD_W'(mul_b);

    assign hi_val   = {1'b0, r_prod} + (PROD_W + 1)'(r_fd);
    assign round_up = r_d1 < r_d2;
    assign dec_sh   = (r_exp == '0) ? SHIFT_ZERO : SHIFT_BASE - SH_W'(r_exp);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_command;
            r_target <= i_target_rate;
            r_mant   <= i_code_mantissa;
            r_exp    <= i_code_exponent;
            r_fd     <= (r_crystal > r_thresh) ? (r_crystal >> 1) : r_crystal;
        end
        if (i_cmd.prep) begin
            r_p0 <= {1'b0, r_fd, {MANT_W{1'b0}}} - PROD_W'(r_fd);
            r_p1 <= {r_fd, {MULB_W{1'b0}}} - PROD_W'(r_fd);
            r_se <= '0;
        end
        if (i_cmd.search_step) begin
            r_se <= r_se + 1'b1;
        end
        if (i_cmd.div_init) begin
            r_t   <= t_val;
            r_dvd <= t_val;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= q_bit ? CRYSTAL_W'(rem_sh - {1'b0, r_fd}) : CRYSTAL_W'(rem_sh);
            r_q   <= {r_q[MANT_W-2:0], q_bit};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.mul_round || i_cmd.mul_dec) begin
            r_prod <= prod;
        end
        // distances to both neighbors, wrapped to 64 bits
        if (i_cmd.diff) begin
            r_d1 <= DIFF_W'(hi_val) - DIFF_W'(r_t);
            r_d2 <= DIFF_W'(r_t) - DIFF_W'(r_prod);
        end
        if (i_cmd.out_enc) begin
            o_found_mantissa <= (r_fd == '0) ? '0 : r_q + MANT_W'(round_up);
            o_found_exponent <= r_se;
            o_rate_value     <= '0;
        end
        if (i_cmd.out_dec) begin
            o_found_mantissa <= '0;
            o_found_exponent <= '0;
            o_rate_value     <= RATE_W'(r_prod >> dec_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_enc || i_cmd.out_dec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_stat.is_dec      = r_cmd == CMD_DECODE;
        o_stat.search_done = (r_se == EXPONENT_LIMIT) || search_hit;
        o_stat.fd_zero     = r_fd == '0;
        o_stat.div_last    = r_cnt == CNT_W'(DIV_STEPS - 1);
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    `DMEC_ASSERT_IMPL(a_search_bound, i_clk, i_rst_n, i_cmd.search_step, r_se < EXPONENT_LIMIT, "exponent search stepped past the limit")
    `DMEC_ASSERT_NEXT(a_rem_bound, i_clk, i_rst_n, i_cmd.div_step, r_rem < r_fd, "division remainder not below divisor")
    `DMEC_ASSERT_IMPL(a_div_len, i_clk, i_rst_n, i_cmd.div_step, r_cnt < CNT_W'(DIV_STEPS), "division ran past its step count")
    `DMEC_ASSERT_IMPL(a_out_load, i_clk, i_rst_n, i_cmd.out_enc || i_cmd.out_dec, !r_out_valid || i_out_ready, "result loaded over one not yet taken")

endmodule

`default_nettype wire
